FILE: rtl/core/hfa_pkg.sv
`timescale 1ns / 1ps

package hfa_pkg;

  // command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // fit_mode codes
  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  // configuration register indexes
  localparam logic CFG_FIT_MODE     = 1'b0;
  localparam logic CFG_HOLES_IN_USE = 1'b1;

  // fixed field widths
  localparam int unsigned IdxWidth   = 4;
  localparam int unsigned SizeWidth  = 16;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned TotalWidth = 32;
  localparam int unsigned CfgWidth   = 5;

  localparam logic [CountWidth-1:0] HolesInUseReset = 5'd16;

  // control from the sequencer to the shared fit unit
  typedef struct packed {
    logic start;
    logic step;
    logic smallest;
  } scan_ctrl_t;

endpackage

FILE: rtl/core/hfa_fit_unit.sv
`timescale 1ns / 1ps

module hfa_fit_unit
  import hfa_pkg::*;
#(
  parameter int unsigned SIZE_BITS = 16,
  parameter int unsigned ADDR_BITS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scan_ctrl_t            ctrl_i,
  input  logic [SIZE_BITS-1:0]  req_size_i,
  input  logic [SIZE_BITS-1:0]  data_i,
  input  logic [ADDR_BITS-1:0]  data_idx_i,
  input  logic [TotalWidth-1:0] acc_init_i,
  output logic                  found_o,
  output logic [ADDR_BITS-1:0]  pick_o,
  output logic [SIZE_BITS-1:0]  best_o,
  output logic [TotalWidth-1:0] acc_o
);

  logic                  found_q, found_d;
  logic [ADDR_BITS-1:0]  pick_q, pick_d;
  logic [SIZE_BITS-1:0]  best_q, best_d;
  logic [TotalWidth-1:0] acc_q, acc_d;
  logic [TotalWidth:0]   sum;
  logic                  fits;
  logic                  take;

  assign fits = (data_i >= req_size_i);
  assign take = fits && (!found_q || (ctrl_i.smallest && (data_i < best_q)));
  assign sum  = {1'b0, acc_q} + (TotalWidth + 1)'(data_i);

  always_comb begin
    found_d = found_q;
    pick_d  = pick_q;
    best_d  = best_q;
    acc_d   = acc_q;
    if (ctrl_i.start) begin
      found_d = 1'b0;
      acc_d   = acc_init_i;
    end else if (ctrl_i.step) begin
      // saturating running total of free space
      acc_d = sum[TotalWidth] ? '1 : sum[TotalWidth-1:0];
      if (take) begin
        found_d = 1'b1;
        pick_d  = data_idx_i;
        best_d  = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      pick_q  <= '0;
      best_q  <= '0;
      acc_q   <= '0;
    end else begin
      found_q <= found_d;
      pick_q  <= pick_d;
      best_q  <= best_d;
      acc_q   <= acc_d;
    end
  end

  assign found_o = found_q;
  assign pick_o  = pick_q;
  assign best_o  = best_q;
  assign acc_o   = acc_q;

endmodule

FILE: rtl/core/hole_fit_allocator_top.sv
`timescale 1ns / 1ps

// channel  direction  handshake                 word
// in       input      in_valid_i / in_stall_o   command_i, hole_index_i, size_i
// out      output     out_valid_o / out_stall_i granted_o, hole_number_o, hole_remaining_o,
//                                               fragmentation_total_o, fragmentation_seen_o
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// a load goes straight to the result state; a request first searches n holes,
// n = min(holes_in_use, NUM_HOLES), and goes straight to the result state when n is zero
// the request time is set by one compare/add unit visiting one hole per cycle
// through the single registered read port of the hole table
// reset is asynchronous; valid bits mark the table empty at once, no clearing pass
// one word is taken at a time; the result register waits under out_stall_i and
// the block takes the next word while that result is still waiting

module hole_fit_allocator_top
  import hfa_pkg::*;
#(
  parameter int unsigned NUM_HOLES = 16,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CfgWidth-1:0]   cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [IdxWidth-1:0]   hole_index_i,
  input  logic [SizeWidth-1:0]  size_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  granted_o,
  output logic [IdxWidth-1:0]   hole_number_o,
  output logic [SizeWidth-1:0]  hole_remaining_o,
  output logic [TotalWidth-1:0] fragmentation_total_o,
  output logic                  fragmentation_seen_o
);

  localparam int unsigned AW = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  state_e                state_q, state_d;
  logic                  cmd_q, cmd_d;
  logic [IdxWidth-1:0]   idx_q, idx_d;
  logic [SIZE_BITS-1:0]  sz_q, sz_d;
  logic [CountWidth-1:0] n_q, n_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  pend_q, pend_d;
  logic                  last_q, last_d;
  logic [AW-1:0]         tag_q, tag_d;
  logic                  fit_mode_q, fit_mode_d;
  logic [CountWidth-1:0] holes_q, holes_d;
  logic [TotalWidth-1:0] frag_q, frag_d;
  logic                  flag_q, flag_d;
  logic                  out_valid_q, out_valid_d;
  logic                  granted_q, granted_d;
  logic [IdxWidth-1:0]   number_q, number_d;
  logic [SizeWidth-1:0]  remain_q, remain_d;

  logic                  in_accept;
  logic                  out_free;
  logic [CountWidth-1:0] n_sat;
  logic                  load_in_range;

  // hole table
  logic [SIZE_BITS-1:0]  mem_q [NUM_HOLES];
  logic [NUM_HOLES-1:0]  vld_q;
  logic [SIZE_BITS-1:0]  rd_data_q;
  logic                  rd_vld_q;
  logic [AW-1:0]         rd_addr;
  logic                  mem_we;
  logic [AW-1:0]         wr_addr;
  logic [SIZE_BITS-1:0]  wr_data;
  logic [SIZE_BITS-1:0]  hole_data;

  scan_ctrl_t            scan_ctrl;
  logic                  fu_found;
  logic [AW-1:0]         fu_pick;
  logic [SIZE_BITS-1:0]  fu_best;
  logic [TotalWidth-1:0] fu_acc;

  assign in_accept     = in_valid_i && !in_stall_o;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_free      = !out_valid_q || !out_stall_i;
  assign n_sat         = (32'(holes_q) > NUM_HOLES) ? CountWidth'(NUM_HOLES) : holes_q;
  assign load_in_range = (32'(idx_q) < NUM_HOLES);
  assign rd_addr       = AW'(cnt_q);
  assign hole_data     = rd_vld_q ? rd_data_q : '0;

  assign scan_ctrl.start    = in_accept;
  assign scan_ctrl.step     = (state_q == ST_SCAN) && pend_q;
  assign scan_ctrl.smallest = (fit_mode_q == FIT_BEST);

  hfa_fit_unit #(
    .SIZE_BITS(SIZE_BITS),
    .ADDR_BITS(AW)
  ) u_fit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .req_size_i (sz_q),
    .data_i     (hole_data),
    .data_idx_i (tag_q),
    .acc_init_i (frag_q),
    .found_o    (fu_found),
    .pick_o     (fu_pick),
    .best_o     (fu_best),
    .acc_o      (fu_acc)
  );

  // write port: loads and granted requests, both in the result state
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = fu_pick;
    wr_data = fu_best - sz_q;
    if (state_q == ST_RESULT && out_free) begin
      if (cmd_q == CMD_LOAD) begin
        mem_we  = load_in_range;
        wr_addr = AW'(idx_q);
        wr_data = sz_q;
      end else begin
        mem_we = fu_found;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    sz_d        = sz_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    last_d      = last_q;
    tag_d       = tag_q;
    fit_mode_d  = fit_mode_q;
    holes_d     = holes_q;
    frag_d      = frag_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q;
    granted_d   = granted_q;
    number_d    = number_q;
    remain_d    = remain_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIT_MODE:     fit_mode_d = cfg_wdata_i[0];
        CFG_HOLES_IN_USE: holes_d    = cfg_wdata_i;
        default:          ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_d  = command_i;
          idx_d  = hole_index_i;
          sz_d   = SIZE_BITS'(size_i);
          n_d    = n_sat;
          cnt_d  = '0;
          pend_d = 1'b0;
          last_d = 1'b0;
          if (command_i == CMD_REQUEST && n_sat != '0) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        // read issue runs ahead of the compare: each hole read here is compared in the cycle after
        if (cnt_q != n_q) begin
          cnt_d  = cnt_q + 1'b1;
          pend_d = 1'b1;
          tag_d  = AW'(cnt_q);
          last_d = (CountWidth'(cnt_q + 1'b1) == n_q);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && last_q) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (cmd_q == CMD_LOAD) begin
            granted_d = 1'b0;
            number_d  = idx_q;
            remain_d  = load_in_range ? SizeWidth'(sz_q) : '0;
          end else if (fu_found) begin
            granted_d = 1'b1;
            number_d  = IdxWidth'(fu_pick);
            remain_d  = SizeWidth'(fu_best - sz_q);
          end else begin
            granted_d = 1'b0;
            number_d  = '0;
            remain_d  = '0;
            frag_d    = fu_acc;
            flag_d    = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= CMD_LOAD;
      idx_q       <= '0;
      sz_q        <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      last_q      <= 1'b0;
      tag_q       <= '0;
      fit_mode_q  <= FIT_FIRST;
      holes_q     <= HolesInUseReset;
      frag_q      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      granted_q   <= 1'b0;
      number_q    <= '0;
      remain_q    <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      idx_q       <= idx_d;
      sz_q        <= sz_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      last_q      <= last_d;
      tag_q       <= tag_d;
      fit_mode_q  <= fit_mode_d;
      holes_q     <= holes_d;
      frag_q      <= frag_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
      granted_q   <= granted_d;
      number_q    <= number_d;
      remain_q    <= remain_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign granted_o             = granted_q;
  assign hole_number_o         = number_q;
  assign hole_remaining_o      = remain_q;
  assign fragmentation_total_o = frag_q;
  assign fragmentation_seen_o  = flag_q;

  a_frag_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> frag_q >= $past(frag_q))
    else $error("fragmentation total decreased");

  a_flag_on_failure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flag_q) |-> out_valid_q && !granted_q)
    else $error("sticky flag set without a failed request word");

  a_last_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && pend_q && last_q |=> state_q == ST_RESULT)
    else $error("search did not finish after the last hole");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !mem_we && in_stall_o)
    else $error("table written or word taken during a search");

endmodule

FILE: verif/hole_fit_checker.sv
`timescale 1ns / 1ps

module hole_fit_checker
  import hfa_pkg::*;
#(
  parameter int unsigned NUM_HOLES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CfgWidth-1:0]   cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  command_i,
  input  logic [IdxWidth-1:0]   hole_index_i,
  input  logic [SizeWidth-1:0]  size_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  granted_i,
  input  logic [IdxWidth-1:0]   hole_number_i,
  input  logic [SizeWidth-1:0]  hole_remaining_i,
  input  logic [TotalWidth-1:0] fragmentation_total_i,
  input  logic                  fragmentation_seen_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           words_pending_o
);

  typedef struct packed {
    logic                  granted;
    logic [IdxWidth-1:0]   number;
    logic [SizeWidth-1:0]  remaining;
    logic [TotalWidth-1:0] frag_total;
    logic                  frag_seen;
  } alloc_word_t;

  logic [SizeWidth-1:0]  hole_size [NUM_HOLES];
  logic [TotalWidth-1:0] frag_sum;
  logic                  frag_flag;
  logic                  fit_mode;
  logic [CountWidth-1:0] holes_in_use;

  alloc_word_t expected_words[$];
  int unsigned mismatches = 0;

  // applies one input word to the local copy of the hole table
  function automatic alloc_word_t serve_word(input logic cmd,
                                             input logic [IdxWidth-1:0] idx,
                                             input logic [SizeWidth-1:0] sz);
    alloc_word_t      res;
    int unsigned      searched;
    int unsigned      pick;
    logic             found;
    longint unsigned  total;
    res      = '0;
    found    = 1'b0;
    pick     = 0;
    searched = (holes_in_use > NUM_HOLES) ? NUM_HOLES : holes_in_use;
    if (cmd == CMD_LOAD) begin
      res.number = idx;
      if (idx < NUM_HOLES) begin
        hole_size[idx] = sz;
        res.remaining  = sz;
      end
    end else begin
      // first fit stops at the first hole that fits, best fit keeps the smallest
      for (int j = 0; j < searched && !(found && fit_mode == FIT_FIRST); j++) begin
        if (hole_size[j] >= sz) begin
          if (!found) begin
            found = 1'b1;
            pick  = j;
          end else if (hole_size[j] < hole_size[pick]) begin
            pick = j;
          end
        end
      end
      if (found) begin
        hole_size[pick] = hole_size[pick] - sz;
        res.granted     = 1'b1;
        res.number      = IdxWidth'(pick);
        res.remaining   = hole_size[pick];
      end else begin
        total = frag_sum;
        for (int j = 0; j < searched; j++) total += hole_size[j];
        if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
        frag_sum  = TotalWidth'(total);
        frag_flag = 1'b1;
      end
    end
    res.frag_total = frag_sum;
    res.frag_seen  = frag_flag;
    return res;
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", field, want, got);
    end
  endfunction

  function automatic void compare_word(input alloc_word_t want);
    compare_field("granted", 32'(want.granted), 32'(granted_i));
    compare_field("hole_number", 32'(want.number), 32'(hole_number_i));
    compare_field("hole_remaining", 32'(want.remaining), 32'(hole_remaining_i));
    compare_field("fragmentation_total", want.frag_total, fragmentation_total_i);
    compare_field("fragmentation_seen", 32'(want.frag_seen), 32'(fragmentation_seen_i));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_HOLES; i++) hole_size[i] = '0;
      frag_sum     = '0;
      frag_flag    = 1'b0;
      fit_mode     = FIT_FIRST;
      holes_in_use = HolesInUseReset;
      expected_words.delete();
      words_pending_o  <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FIT_MODE) fit_mode = cfg_wdata_i[0];
        else holes_in_use = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: granted %0b hole %0d remaining %0h",
                     granted_i, hole_number_i, hole_remaining_i);
        end else begin
          compare_word(expected_words.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_words.push_back(serve_word(command_i, hole_index_i, size_i));
      words_pending_o  <= expected_words.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

FILE: verif/tb_hole_fit_allocator_top.sv
`timescale 1ns / 1ps

module tb_hole_fit_allocator_top;
  import hfa_pkg::*;

  localparam int unsigned NUM_HOLES    = 16;
  localparam int unsigned SETTLE       = 24;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned BIG_FAILS    = 24;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic                  cfg_idx_i    = CFG_FIT_MODE;
  logic [CfgWidth-1:0]   cfg_wdata_i  = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic                  command_i    = CMD_LOAD;
  logic [IdxWidth-1:0]   hole_index_i = '0;
  logic [SizeWidth-1:0]  size_i       = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic                  granted_o;
  logic [IdxWidth-1:0]   hole_number_o;
  logic [SizeWidth-1:0]  hole_remaining_o;
  logic [TotalWidth-1:0] fragmentation_total_o;
  logic                  fragmentation_seen_o;

  int unsigned mismatch_count;
  int unsigned words_pending;
  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;
  logic        calm        = 1'b0;

  hole_fit_allocator_top #(
    .NUM_HOLES(NUM_HOLES),
    .SIZE_BITS(SizeWidth)
  ) DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .command_i            (command_i),
    .hole_index_i         (hole_index_i),
    .size_i               (size_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .granted_o            (granted_o),
    .hole_number_o        (hole_number_o),
    .hole_remaining_o     (hole_remaining_o),
    .fragmentation_total_o(fragmentation_total_o),
    .fragmentation_seen_o (fragmentation_seen_o)
  );

  hole_fit_checker #(
    .NUM_HOLES(NUM_HOLES)
  ) u_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_i           (in_stall_o),
    .command_i            (command_i),
    .hole_index_i         (hole_index_i),
    .size_i               (size_i),
    .out_valid_i          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .granted_i            (granted_o),
    .hole_number_i        (hole_number_o),
    .hole_remaining_i     (hole_remaining_o),
    .fragmentation_total_i(fragmentation_total_o),
    .fragmentation_seen_i (fragmentation_seen_o),
    .mismatch_count_o     (mismatch_count),
    .words_pending_o      (words_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 19);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic cmd, input logic [IdxWidth-1:0] idx,
                           input logic [SizeWidth-1:0] sz);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    hole_index_i <= idx;
    size_i       <= sz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  // sender holds off until every outstanding result has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic fit, input logic [CfgWidth-1:0] holes);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_FIT_MODE;
    cfg_wdata_i <= CfgWidth'(fit);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_HOLES_IN_USE;
    cfg_wdata_i <= holes;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [SizeWidth-1:0] pick_size();
    case ($urandom_range(6))
      0:       return '0;
      1:       return '1;
      2, 3:    return SizeWidth'($urandom_range(255));
      4:       return SizeWidth'($urandom_range(4095));
      default: return SizeWidth'($urandom());
    endcase
  endfunction

  // a few loads followed by a few requests against them
  task automatic run_burst();
    int unsigned loads;
    int unsigned asks;
    loads = $urandom_range(1, 6);
    asks  = $urandom_range(1, 6);
    repeat (loads) send_word(CMD_LOAD, IdxWidth'($urandom_range(15)), pick_size());
    repeat (asks) send_word(CMD_REQUEST, IdxWidth'($urandom_range(15)), pick_size());
  endtask

  task automatic run_noise();
    send_word(logic'($urandom_range(1)), IdxWidth'($urandom()), SizeWidth'($urandom()));
  endtask

  initial begin
    logic                fit;
    logic [CfgWidth-1:0] holes;
    int unsigned         quota;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: first fit over all holes, table empty
    send_word(CMD_REQUEST, 4'd0, 16'd0);      // zero request fits an empty hole
    send_word(CMD_REQUEST, 4'd15, 16'd1);     // nothing fits, adds nothing
    send_word(CMD_LOAD, 4'd0, 16'd40);
    send_word(CMD_LOAD, 4'd3, 16'd100);
    send_word(CMD_LOAD, 4'd5, 16'd60);
    send_word(CMD_LOAD, 4'd9, 16'd60);
    send_word(CMD_LOAD, 4'd15, 16'hFFFF);
    send_word(CMD_REQUEST, 4'd0, 16'd50);
    send_word(CMD_REQUEST, 4'd0, 16'hFFFF);
    send_word(CMD_REQUEST, 4'd0, 16'hFFFF);
    drain_results();

    set_mode(FIT_BEST, 5'd16);
    send_word(CMD_REQUEST, 4'd0, 16'd55);     // tie between two holes
    send_word(CMD_REQUEST, 4'd0, 16'd41);
    send_word(CMD_REQUEST, 4'd0, 16'd0);
    drain_results();

    set_mode(FIT_FIRST, 5'd0);                // nothing searched
    send_word(CMD_REQUEST, 4'd0, 16'd0);
    send_word(CMD_LOAD, 4'd10, 16'd7);
    drain_results();

    set_mode(FIT_BEST, 5'd31);                // clamps to the table size
    send_word(CMD_REQUEST, 4'd0, 16'd60);
    drain_results();

    set_mode(FIT_FIRST, 5'd1);
    send_word(CMD_REQUEST, 4'd0, 16'd41);
    send_word(CMD_REQUEST, 4'd0, 16'd40);
    drain_results();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0:       begin fit = FIT_FIRST; holes = 5'd16; end
        1:       begin fit = FIT_BEST;  holes = 5'd1;  end
        2:       begin fit = FIT_BEST;  holes = 5'd16; end
        3:       begin fit = FIT_FIRST; holes = 5'd0;  end
        4:       begin fit = FIT_BEST;  holes = 5'd31; end
        default: begin fit = logic'($urandom_range(1)); holes = CfgWidth'($urandom()); end
      endcase
      set_mode(fit, holes);
      calm  = (phase == 2);
      quota = words_sent + 185;
      while (words_sent < quota) begin
        if ($urandom_range(9) < 8) run_burst();
        else run_noise();
      end
      drain_results();
    end
    calm = 1'b0;

    // large holes and requests that never fit grow the fragmentation total fast
    set_mode(FIT_FIRST, 5'd16);
    for (int i = 0; i < NUM_HOLES; i++) send_word(CMD_LOAD, IdxWidth'(i), 16'hFFFE);
    repeat (BIG_FAILS) send_word(CMD_REQUEST, IdxWidth'($urandom()), 16'hFFFF);
    send_word(CMD_REQUEST, 4'd0, 16'hFFFE);
    send_word(CMD_LOAD, 4'd2, 16'd0);
    send_word(CMD_REQUEST, 4'd0, 16'hFFFF);
    drain_results();

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
